// File: hdl/kvt_pkg.sv
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and constants for the key/value table
// Capacity, operation and status codes, and the control bundle sent to cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

   // number of entries, one cell each
   localparam int CAPACITY = 16;
   // width of the internal entry counter, able to hold CAPACITY itself
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // request kinds
   localparam logic [1:0] OP_FIND   = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;

   // result status codes
   localparam logic [1:0] ST_PRESENT = 2'd0;
   localparam logic [1:0] ST_NEW     = 2'd1;
   localparam logic [1:0] ST_ABSENT  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   // control bundle from the sequencer to every cell
   typedef struct packed {
      logic       match;    // compare phase: capture hit and free-slot claim
      logic       apply;    // update phase: write from the captured decision
      logic [1:0] kind;     // operation of the request in flight
      logic       any_hit;  // some cell matched during the compare phase
   } cell_ctl_type;

endpackage

`default_nettype wire

// File: hdl/key_value_table.sv
// ----------------------------------------------------------------------------
// key_value_table: bounded table of unique key/data pairs
// Find, insert-or-update and delete over a row of entry cells.
// ----------------------------------------------------------------------------
//  channel   ports                                   transfer
//  request   start, busy, req_kind/key/value          start && !busy
//  response  rsp_valid, rsp_status/data_out/count     rsp_valid, one cycle
//
//  each request has a compare cycle in which every cell checks the key and
//  the free-slot chain settles, then an update cycle in which the cells
//  write. busy is high during the compare cycle only.
//  the response is shown during the update cycle; a new request may be
//  accepted at that same edge. the receiver cannot stall.
//  reset clears all valid bits and the entry count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_value_table (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire  [1:0]         req_kind,
   input  wire  signed [31:0] req_key,
   input  wire  signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data_out,
   output logic [4:0]         rsp_count
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MATCH = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [1:0]                 kind_ff, kind_in;
   logic [31:0]                key_ff, key_in;
   logic [31:0]                value_ff, value_in;
   logic                       any_hit_ff, any_hit_in;
   logic [kvt_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 status_ff, status_in;
   logic [31:0]                rdata_ff, rdata_in;
   logic                       accept;
   kvt_pkg::cell_ctl_type      ctl;

   logic                       free_chain [kvt_pkg::CAPACITY+1];
   logic                       hit_chain  [kvt_pkg::CAPACITY+1];
   logic [31:0]                rdata_chain[kvt_pkg::CAPACITY+1];

   assign busy   = (state_ff == S_MATCH);
   assign accept = start && !busy;

   // cell control
   always_comb begin
      ctl.match   = (state_ff == S_MATCH);
      ctl.apply   = (state_ff == S_APPLY);
      ctl.kind    = kind_ff;
      ctl.any_hit = any_hit_ff;
   end

   // row of entry cells
   assign free_chain[0]  = 1'b0;
   assign hit_chain[0]   = 1'b0;
   assign rdata_chain[0] = 32'd0;

   for (genvar i = 0; i < kvt_pkg::CAPACITY; i++) begin : g_cell
      kvt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (key_ff),
         .value      (value_ff),
         .free_prev  (free_chain[i]),
         .free_next  (free_chain[i+1]),
         .hit_prev   (hit_chain[i]),
         .hit_next   (hit_chain[i+1]),
         .rdata_prev (rdata_chain[i]),
         .rdata_next (rdata_chain[i+1])
      );
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  state_in = accept ? S_MATCH : S_IDLE;
         S_MATCH: state_in = S_APPLY;
         S_APPLY: state_in = accept ? S_MATCH : S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // request capture
   always_comb begin
      kind_in  = kind_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (accept) begin
         kind_in  = req_kind;
         key_in   = req_key;
         value_in = req_value;
      end
   end

   // result and count from the compare phase
   always_comb begin
      any_hit_in   = any_hit_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      rdata_in     = rdata_ff;
      if (state_ff == S_MATCH) begin
         any_hit_in   = hit_chain[kvt_pkg::CAPACITY];
         rsp_valid_in = 1'b1;
         status_in    = kvt_pkg::ST_ABSENT;
         rdata_in     = 32'd0;
         unique case (kind_ff)
            kvt_pkg::OP_FIND: begin
               if (hit_chain[kvt_pkg::CAPACITY]) begin
                  status_in = kvt_pkg::ST_PRESENT;
                  rdata_in  = rdata_chain[kvt_pkg::CAPACITY];
               end
            end
            kvt_pkg::OP_INSERT: begin
               if (hit_chain[kvt_pkg::CAPACITY]) begin
                  status_in = kvt_pkg::ST_PRESENT;
               end else if (free_chain[kvt_pkg::CAPACITY]) begin
                  status_in = kvt_pkg::ST_NEW;
                  count_in  = count_ff + kvt_pkg::CNT_W'(1);
               end else begin
                  status_in = kvt_pkg::ST_FULL;
               end
            end
            kvt_pkg::OP_DELETE: begin
               if (hit_chain[kvt_pkg::CAPACITY]) begin
                  status_in = kvt_pkg::ST_PRESENT;
                  count_in  = count_ff - kvt_pkg::CNT_W'(1);
               end
            end
            default: status_in = kvt_pkg::ST_ABSENT;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         any_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         any_hit_ff   <= any_hit_in;
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      rdata_ff  <= rdata_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_data_out = rdata_ff;
   assign rsp_count    = 5'(count_ff);

   // checks
   a_rsp_in_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_APPLY))
      else $error("response outside update cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy && !rsp_valid))
      else $error("accepted request did not enter compare cycle");

   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("compare cycle not followed by a response");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= kvt_pkg::CNT_W'(kvt_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_new_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == kvt_pkg::ST_NEW)) |->
         (count_ff == $past(count_ff) + kvt_pkg::CNT_W'(1)))
      else $error("insert of new key did not raise the count");

endmodule

`default_nettype wire

// File: hdl/kvt_cell.sv
// ----------------------------------------------------------------------------
// kvt_cell: one entry of the key/value table
// Holds valid, key and data; compares against the request key, claims the
// lowest free slot along the free chain, and merges its data onto the read chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kvt_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire kvt_pkg::cell_ctl_type ctl,
   input  wire  [31:0]          key,
   input  wire  [31:0]          value,
   input  wire                  free_prev,
   output logic                 free_next,
   input  wire                  hit_prev,
   output logic                 hit_next,
   input  wire  [31:0]          rdata_prev,
   output logic [31:0]          rdata_next
);

   logic        valid_ff, valid_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] data_ff, data_in;
   logic        hit_ff, hit_in;
   logic        cand_ff, cand_in;
   logic        hit;
   logic        alloc;

   // compare and chain hand-off
   always_comb begin
      hit        = valid_ff && (key_ff == key);
      hit_next   = hit_prev | hit;
      free_next  = free_prev | ~valid_ff;
      rdata_next = rdata_prev | (hit ? data_ff : 32'd0);
   end

   // captured decision from the compare phase
   always_comb begin
      hit_in  = hit_ff;
      cand_in = cand_ff;
      if (ctl.match) begin
         hit_in  = hit;
         cand_in = ~valid_ff & ~free_prev;
      end
   end

   // update phase
   always_comb begin
      alloc    = ctl.apply && (ctl.kind == kvt_pkg::OP_INSERT) && !ctl.any_hit && cand_ff;
      valid_in = valid_ff;
      key_in   = key_ff;
      data_in  = data_ff;
      if (ctl.apply && hit_ff && (ctl.kind == kvt_pkg::OP_INSERT)) begin
         data_in = value;
      end
      if (alloc) begin
         valid_in = 1'b1;
         key_in   = key;
         data_in  = value;
      end
      if (ctl.apply && hit_ff && (ctl.kind == kvt_pkg::OP_DELETE)) begin
         valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
         cand_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
         cand_ff  <= cand_in;
      end
   end

   // entry payload
   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      data_ff <= data_in;
   end

endmodule

`default_nettype wire
